@@ src/jacobi_stencil_relaxation_assert.svh @@
// Assertion helpers for the checker of this block.
`ifndef JACOBI_STENCIL_RELAXATION_ASSERT_SVH
`define JACOBI_STENCIL_RELAXATION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define JSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsr check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define JSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsr check failed");

`endif

@@ src/jsr_pkg.sv @@
`timescale 1ns / 1ps
package jsr_pkg;

  localparam int MAX_SIDE_DEF   = 64;
  localparam int VALUE_BITS_DEF = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_RUN   = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_SIZE  = 2'd0;
  localparam cfg_idx_t CFG_THRESHOLD  = 2'd1;
  localparam cfg_idx_t CFG_MAX_SWEEPS = 2'd2;

  typedef logic [2:0] tap_t;
  localparam tap_t TAP_CENTER = 3'd0;
  localparam tap_t TAP_UP     = 3'd1;
  localparam tap_t TAP_DOWN   = 3'd2;
  localparam tap_t TAP_LEFT   = 3'd3;
  localparam tap_t TAP_RIGHT  = 3'd4;

  typedef struct packed {
    op_t         operation;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic        is_read;
    logic [15:0] cell_value;
    logic [15:0] sweep_count;
    logic        cap_hit;
  } result_t;

  typedef struct packed {
    logic        clr;
    logic        host_wr;
    logic        host_rd;
    logic        sweep_start;
    logic        issue;
    tap_t        tap;
    logic        acc;
    logic        mul;
    logic        fix;
    logic        cell_wr;
    logic        flip;
    logic        out_rd;
    logic        out_run;
    logic [15:0] count;
    logic        cap_hit;
  } cmd_t;

  typedef struct packed {
    logic        clr_last;
    logic        last_cell;
    logic        changed;
    logic        same;
    logic [15:0] max_sweeps;
  } status_t;

endpackage

@@ src/jsr_ctrl.sv @@
`timescale 1ns / 1ps
module jsr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  jsr_pkg::op_t     operation,
  output logic             result_valid,
  input  logic             result_stall,
  output jsr_pkg::cmd_t    cmd,
  input  jsr_pkg::status_t status
);
  import jsr_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RDOUT = 10'b0000000100,
    S_TAP   = 10'b0000001000,
    S_ACC   = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_FIX   = 10'b0001000000,
    S_WR    = 10'b0010000000,
    S_SEND  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t      state, state_next;
  tap_t        tap, tap_next;
  logic [15:0] count, count_next;
  logic [15:0] cap, cap_next;
  logic        hit, hit_next;
  logic        accept, out_free;
  logic [15:0] cnt1;

  assign item_stall = (state != S_IDLE) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign cnt1       = count + 16'd1;

  always_comb begin
    state_next = state;
    tap_next   = tap;
    count_next = count;
    cap_next   = cap;
    hit_next   = hit;
    cmd        = '0;
    cmd.tap    = tap;
    cmd.count  = count;
    cmd.cap_hit = hit;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_WRITE: cmd.host_wr = 1'b1;
            OP_READ: begin
              cmd.host_rd = 1'b1;
              state_next  = S_RDOUT;
            end
            OP_RUN: begin
              cmd.sweep_start = 1'b1;
              count_next = '0;
              cap_next   = (status.max_sweeps == 16'd0) ? 16'd1 : status.max_sweeps;
              tap_next   = TAP_CENTER;
              state_next = S_TAP;
            end
            default: ;
          endcase
        end
      end
      S_RDOUT: begin
        cmd.out_rd = 1'b1;
        state_next = S_IDLE;
      end
      S_TAP: begin
        cmd.issue = 1'b1;
        cmd.acc   = (tap != TAP_CENTER);
        tap_next  = tap + 3'd1;
        if (tap == TAP_RIGHT) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.cell_wr = 1'b1;
        tap_next    = TAP_CENTER;
        state_next  = status.last_cell ? S_SEND : S_TAP;
      end
      S_SEND: begin
        if (!status.changed || cnt1 >= cap) begin
          cmd.flip   = 1'b1;
          count_next = cnt1;
          hit_next   = status.changed;
          state_next = S_DONE;
        end else if (status.same) begin
          // grid is a fixed point: the remaining sweeps only alternate grids
          cmd.flip   = ~(cap[0] ^ cnt1[0]);
          count_next = cap;
          hit_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.flip        = 1'b1;
          cmd.sweep_start = 1'b1;
          count_next      = cnt1;
          tap_next        = TAP_CENTER;
          state_next      = S_TAP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_run = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      tap          <= TAP_CENTER;
      count        <= '0;
      cap          <= 16'd1;
      hit          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      count <= count_next;
      cap   <= cap_next;
      hit   <= hit_next;
      if (cmd.out_rd || cmd.out_run) result_valid <= 1'b1;
      else if (!result_stall)        result_valid <= 1'b0;
    end
  end

endmodule

@@ src/jsr_dp.sv @@
`timescale 1ns / 1ps
module jsr_dp #(
  parameter int MAX_SIDE   = jsr_pkg::MAX_SIDE_DEF,
  parameter int VALUE_BITS = jsr_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  jsr_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data,
  input  jsr_pkg::item_t    item,
  input  jsr_pkg::cmd_t     cmd,
  output jsr_pkg::status_t  status,
  output jsr_pkg::result_t  result
);
  import jsr_pkg::*;

  localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_SIDE + 1);
  localparam int VB    = VALUE_BITS;
  localparam int SW    = VB + 3;
  localparam int SH    = VB + 5;
  localparam int MW    = SH - 1;
  localparam int PW    = SW + MW;
  localparam logic [MW-1:0] M3 = MW'((64'd1 << SH) / 3);
  localparam logic [MW-1:0] M4 = MW'((64'd1 << SH) / 4);
  localparam logic [MW-1:0] M5 = MW'((64'd1 << SH) / 5);
  localparam logic [SW-1:0] VMAX = SW'((64'd1 << VB) - 64'd1);

  logic [6:0]    grid_size;
  logic [15:0]   threshold;
  logic [15:0]   max_sweeps;
  logic [NW-1:0] n;
  logic [CW-1:0] last_idx;

  logic [VB-1:0] grid_a [DEPTH];
  logic [VB-1:0] grid_b [DEPTH];
  logic [VB-1:0] rdata_a, rdata_b, rdat;
  logic          cur_b;
  logic [AW-1:0] clr_addr;

  logic [CW-1:0] r, c, rr, cc;
  logic          inb, inb_q, rd_inside;
  tap_t          tap_q;
  logic          in_grid;
  logic [AW-1:0] host_addr, rd_addr, wa;
  logic          we_a, we_b;
  logic [VB-1:0] wd;

  logic [SW-1:0] sum;
  logic [VB-1:0] old, qreg, diff;
  logic [PW-1:0] prod;
  logic [MW-1:0] mval;
  logic [SW-1:0] dv, q0, r0, q;
  logic          edge_r, edge_c;
  logic          changed, same;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= 7'd64;
      threshold  <= 16'd4096;
      max_sweeps <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE:  grid_size  <= cfg_data[6:0];
        CFG_THRESHOLD:  threshold  <= cfg_data;
        CFG_MAX_SWEEPS: max_sweeps <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_size < 7'd2)                  n = NW'(2);
    else if (32'(grid_size) > MAX_SIDE)    n = NW'(MAX_SIDE);
    else                                   n = NW'(grid_size);
  end
  assign last_idx = CW'(n - NW'(1));

  assign in_grid   = (32'(item.row) < 32'(n)) && (32'(item.col) < 32'(n));
  assign host_addr = {CW'(item.row), CW'(item.col)};

  always_comb begin
    rr  = r;
    cc  = c;
    inb = 1'b1;
    case (cmd.tap)
      TAP_UP:    begin rr = r - CW'(1); inb = (r != '0);       end
      TAP_DOWN:  begin rr = r + CW'(1); inb = (r != last_idx); end
      TAP_LEFT:  begin cc = c - CW'(1); inb = (c != '0);       end
      TAP_RIGHT: begin cc = c + CW'(1); inb = (c != last_idx); end
      default: ;
    endcase
  end
  assign rd_addr = cmd.issue ? {rr, cc} : host_addr;

  // clear writes both grids; host traffic hits the current grid, sweeps the other
  assign we_a = cmd.clr || (cmd.host_wr && in_grid && !cur_b) || (cmd.cell_wr && cur_b);
  assign we_b = cmd.clr || (cmd.host_wr && in_grid && cur_b) || (cmd.cell_wr && !cur_b);
  assign wa   = cmd.clr ? clr_addr : (cmd.host_wr ? host_addr : {r, c});
  assign wd   = cmd.clr ? '0 : (cmd.host_wr ? VB'(item.value) : qreg);

  always_ff @(posedge clk) begin
    rdata_a <= grid_a[rd_addr];
    rdata_b <= grid_b[rd_addr];
    if (we_a) grid_a[wa] <= wd;
    if (we_b) grid_b[wa] <= wd;
  end
  assign rdat = cur_b ? rdata_b : rdata_a;

  assign edge_r = (r == '0) || (r == last_idx);
  assign edge_c = (c == '0) || (c == last_idx);
  always_comb begin
    if (edge_r && edge_c)      begin mval = M3; dv = SW'(3); end
    else if (edge_r || edge_c) begin mval = M4; dv = SW'(4); end
    else                       begin mval = M5; dv = SW'(5); end
  end

  // reciprocal estimate is low by at most two
  assign q0 = SW'(prod[PW-1:SH]);
  assign r0 = sum - q0 * dv;
  always_comb begin
    q = q0;
    if (r0 >= (dv << 1))  q = q0 + SW'(2);
    else if (r0 >= dv)    q = q0 + SW'(1);
  end
  assign diff = (qreg >= old) ? (qreg - old) : (old - qreg);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_b    <= 1'b0;
      clr_addr <= '0;
      r        <= '0;
      c        <= '0;
      changed  <= 1'b0;
      same     <= 1'b1;
    end else begin
      if (cmd.clr)  clr_addr <= clr_addr + AW'(1);
      if (cmd.flip) cur_b <= ~cur_b;
      if (cmd.sweep_start) begin
        r       <= '0;
        c       <= '0;
        changed <= 1'b0;
        same    <= 1'b1;
      end else if (cmd.cell_wr) begin
        if ((VB + 16)'(diff) >= (VB + 16)'(threshold)) changed <= 1'b1;
        if (qreg != old) same <= 1'b0;
        if (c == last_idx) begin
          c <= '0;
          r <= r + CW'(1);
        end else begin
          c <= c + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      inb_q <= inb;
      tap_q <= cmd.tap;
    end
    if (cmd.host_rd) rd_inside <= in_grid;
    if (cmd.sweep_start || cmd.cell_wr) begin
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= sum + (inb_q ? SW'(rdat) : '0);
      if (tap_q == TAP_CENTER) old <= rdat;
    end
    if (cmd.mul) prod <= PW'(sum) * PW'(mval);
    if (cmd.fix) qreg <= (q > VMAX) ? VMAX[VB-1:0] : VB'(q);
    if (cmd.out_rd) begin
      result.is_read     <= 1'b1;
      result.cell_value  <= rd_inside ? 16'(rdat) : 16'd0;
      result.sweep_count <= 16'd0;
      result.cap_hit     <= 1'b0;
    end else if (cmd.out_run) begin
      result.is_read     <= 1'b0;
      result.cell_value  <= 16'd0;
      result.sweep_count <= cmd.count;
      result.cap_hit     <= cmd.cap_hit;
    end
  end

  assign status.clr_last   = &clr_addr;
  assign status.last_cell  = (r == last_idx) && (c == last_idx);
  assign status.changed    = changed;
  assign status.same       = same;
  assign status.max_sweeps = max_sweeps;

endmodule

@@ src/jacobi_stencil_relaxation.sv @@
`timescale 1ns / 1ps
// Jacobi five-point relaxation engine on an n x n grid (n from grid_size, held to
// 2..MAX_SIDE) of unsigned Q4.12 cells, each averaged with its in-grid neighbours,
// kept in two grid memories of 2^(2*ceil(log2 MAX_SIDE)) words (4096 at default).
// After reset both memories are zeroed by a clearing pass, during which no transaction
// is taken (config writes still land). In a sweep each cell reads its five taps one per
// cycle through the single read port of the grid memory, then divides and writes back.
// A run ends at the first sweep with every |change| below threshold, at max_sweeps
// (cap_hit set), or at once when a sweep leaves the grid unchanged but unconverged.
module jacobi_stencil_relaxation #(
  parameter int MAX_SIDE   = jsr_pkg::MAX_SIDE_DEF,
  parameter int VALUE_BITS = jsr_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  jsr_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output jsr_pkg::result_t  result,
  input  logic              cfg_we,
  input  jsr_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);
  import jsr_pkg::*;

  cmd_t    cmd;
  status_t status;

  jsr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (item.operation),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  jsr_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

@@ src/jsr_checker.sv @@
`timescale 1ns / 1ps
`include "jacobi_stencil_relaxation_assert.svh"
module jsr_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input jsr_pkg::result_t result
);
  import jsr_pkg::*;

  `JSR_ASSERT_NXT(a_hold_valid, result_valid && result_stall, result_valid)
  `JSR_ASSERT_IMP(a_run_no_value, result_valid && !result.is_read, result.cell_value == 16'd0)
  `JSR_ASSERT_IMP(a_read_no_count, result_valid && result.is_read, (result.sweep_count == 16'd0) && !result.cap_hit)
  `JSR_ASSERT_IMP(a_run_counted, result_valid && !result.is_read, result.sweep_count != 16'd0)

endmodule

bind jacobi_stencil_relaxation jsr_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import jsr_pkg::*;

  localparam int SIDE = 64;

  // Holds its own copy of both grids and the registers, predicts each transaction.
  class relax_scoreboard;
    bit [15:0] grid [2][SIDE*SIDE];
    bit        cur;
    bit [6:0]  side_reg;
    bit [15:0] thresh_reg;
    bit [15:0] cap_reg;
    result_t   awaited [$];
    int        errors, n_writes, n_reads, n_runs, n_caps, n_sweeps;

    function new();
      cur = 0;
      side_reg = 64;
      thresh_reg = 4096;
      cap_reg = 65535;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [15:0] data);
      case (idx)
        CFG_GRID_SIZE:  side_reg = data[6:0];
        CFG_THRESHOLD:  thresh_reg = data;
        CFG_MAX_SWEEPS: cap_reg = data;
        default: ;
      endcase
    endfunction

    function int side();
      if (side_reg < 2) return 2;
      if (side_reg > SIDE) return SIDE;
      return side_reg;
    endfunction

    function int tap(bit g, int n, int r, int c);
      if (r < 0 || c < 0 || r >= n || c >= n) return 0;
      return grid[g][r*SIDE + c];
    endfunction

    function void note(item_t it);
      int n, cap, cnt, sum, dv, q, old, diff;
      bit changed, same;
      result_t res;
      n = side();
      res = '0;
      case (it.operation)
        OP_WRITE: begin
          n_writes++;
          if (it.row < n && it.col < n) grid[cur][it.row*SIDE + it.col] = it.value;
        end
        OP_READ: begin
          n_reads++;
          res.is_read = 1'b1;
          if (it.row < n && it.col < n) res.cell_value = grid[cur][it.row*SIDE + it.col];
          awaited.push_back(res);
        end
        OP_RUN: begin
          n_runs++;
          cap = (cap_reg == 0) ? 1 : cap_reg;
          cnt = 0;
          forever begin
            changed = 0;
            same = 1;
            for (int r = 0; r < n; r++) begin
              for (int c = 0; c < n; c++) begin
                old = tap(cur, n, r, c);
                sum = old + tap(cur, n, r-1, c) + tap(cur, n, r+1, c)
                    + tap(cur, n, r, c-1) + tap(cur, n, r, c+1);
                dv = 5;
                if (r == 0 || r == n-1) dv--;
                if (c == 0 || c == n-1) dv--;
                q = sum / dv;
                if (q > 65535) q = 65535;
                grid[!cur][r*SIDE + c] = 16'(q);
                diff = (q >= old) ? q - old : old - q;
                if (diff >= thresh_reg) changed = 1;
                if (q != old) same = 0;
              end
            end
            cur = !cur;
            cnt++;
            if (!changed || cnt >= cap) break;
            if (same) begin
              // stuck but unconverged: the rest of the sweeps only swap grids
              if ((cap - cnt) % 2) cur = !cur;
              cnt = cap;
              break;
            end
          end
          n_sweeps += cnt;
          if (changed) n_caps++;
          res.sweep_count = 16'(cnt);
          res.cap_hit = changed;
          awaited.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check(result_t got);
      result_t exp;
      if (awaited.size() == 0) begin
        $error("result with no transaction outstanding: %p", got);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.is_read !== exp.is_read) begin
        $error("is_read: expected %0d, got %0d", exp.is_read, got.is_read);
        errors++;
      end
      if (got.cell_value !== exp.cell_value) begin
        $error("cell_value: expected %0h, got %0h", exp.cell_value, got.cell_value);
        errors++;
      end
      if (got.sweep_count !== exp.sweep_count) begin
        $error("sweep_count: expected %0d, got %0d", exp.sweep_count, got.sweep_count);
        errors++;
      end
      if (got.cap_hit !== exp.cap_hit) begin
        $error("cap_hit: expected %0d, got %0d", exp.cap_hit, got.cap_hit);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 0;
  logic     rst = 1;
  logic     item_valid = 0;
  logic     item_stall;
  item_t    item = '0;
  logic     result_valid;
  logic     result_stall = 0;
  result_t  result;
  logic     cfg_we = 0;
  cfg_idx_t cfg_index = CFG_GRID_SIZE;
  logic [15:0] cfg_data = '0;

  relax_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  jacobi_stencil_relaxation DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(negedge clk) result_stall = ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note(item);
      if (result_valid && !result_stall) sb.check(result);
    end
  end

  task automatic write_reg(cfg_idx_t idx, bit [15:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic setup(bit [15:0] gs, bit [15:0] th, bit [15:0] mx);
    write_reg(CFG_GRID_SIZE, gs);
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_MAX_SWEEPS, mx);
  endtask

  // called at a falling edge; leaves item_valid high after acceptance
  task automatic send(op_t op, int r, int c, bit [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 0;
      @(negedge clk);
    end
    item_valid = 1;
    item.operation = op;
    item.row = 6'(r);
    item.col = 6'(c);
    item.value = v;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(int n_items);
    int n, k;
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 6);
    setup({9'($urandom_range(511)), n[6:0]},
          16'($urandom_range(1) ? $urandom_range(65535) : $urandom_range(600)),
          16'((n > 6) ? $urandom_range(0, 2) : $urandom_range(0, 12)));
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      send(k < 45 ? OP_WRITE : k < 85 ? OP_READ : k < 95 ? OP_RUN : op_t'(2'd3),
           $urandom_range(4) == 0 ? $urandom_range(63) : $urandom_range(n-1),
           $urandom_range(4) == 0 ? $urandom_range(63) : $urandom_range(n-1),
           16'($urandom_range(2) == 0 ? $urandom_range(65535) : $urandom_range(0, 8000)));
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings on an all-zero grid: one sweep converges
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 63, 63, 0);
    drain();

    // clamped size 2, threshold zero, cap zero used as one
    setup(16'd0, 16'd0, 16'd0);
    send(OP_WRITE, 0, 0, 16'hFFFF);
    send(OP_WRITE, 1, 1, 16'h0000);
    send(OP_WRITE, 0, 1, 16'hAAAA);
    send(OP_WRITE, 5, 9, 16'h5555);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 5, 9, 0);
    send(op_t'(2'd3), 63, 63, 16'hFFFF);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 0, 1, 0);
    drain();

    // oversized side clamps to full grid, single sweep
    setup(16'd127, 16'hFFFF, 16'd1);
    send(OP_WRITE, 63, 63, 16'hFFFF);
    send(OP_WRITE, 63, 0, 16'h8001);
    send(OP_READ, 63, 63, 0);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 63, 62, 0);
    send(OP_READ, 62, 0, 0);
    drain();

    // largest cap, threshold zero: ends at a stuck fixed point
    setup(16'd2, 16'd0, 16'hFFFF);
    send(OP_WRITE, 1, 0, 16'h7FFF);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 1, 0, 0);
    drain();

    // regrow: stale cells outside the small grid become visible
    setup(16'd64, 16'd4096, 16'd3);
    send(OP_READ, 63, 63, 0);
    send(OP_READ, 62, 63, 0);
    drain();

    for (int p = 0; p < 30; p++) begin
      send_idle_pct = (p < 10) ? 10 : (p < 20) ? 74 : 0;
      recv_stall_pct = (p < 10) ? 74 : (p < 20) ? 10 : 0;
      random_phase(33);
    end

    $display("Covered %0d writes, %0d reads, %0d runs (%0d sweeps, %0d at cap).",
             sb.n_writes, sb.n_reads, sb.n_runs, sb.n_sweeps, sb.n_caps);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule
